// ===== design/rc4cks_pkg.sv =====
// ----------------------------------------------------------------------------
// RC4 candidate key scorer package
// Shared command and status types, constant tables and key derivation.
// ----------------------------------------------------------------------------
package rc4cks_pkg;

	localparam int SBOX_DEPTH = 256;
	localparam int SBOX_WIDTH = 8;
	localparam int PLAIN_BYTES = 10;
	localparam logic [3:0] LEN_LONG = 4'd15;
	localparam logic [6:0] KEY_SHORT = 7'd76;
	localparam logic [6:0] KEY_LONG = 7'd80;
	localparam logic [7:0] HI_OFFSET = 8'h78;
	localparam logic [7:0] LO_OFFSET = 8'h7a;
	localparam logic [7:0] CASE_BIT = 8'h20;
	localparam logic [3:0] LEN_RESET = 4'd14;

	localparam logic [7:0] CIPHER [PLAIN_BYTES] = '{
		8'h69, 8'h8b, 8'h8f, 8'hb1, 8'h8f, 8'h3b, 8'h4f, 8'h99, 8'h61, 8'h72
	};
	localparam logic [7:0] GOAL [PLAIN_BYTES] = '{
		8'h66, 8'h00, 8'h6c, 8'h00, 8'h61, 8'h00, 8'h67, 8'h00, 8'h7b, 8'h00
	};

	// Commands from the controller to the datapath.
	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_INIT, OP_K1, OP_K2, OP_K3, OP_K4,
		OP_P1, OP_P2, OP_P3, OP_P4, OP_P5, OP_P6, OP_PUB
	} op_t;

	typedef struct packed {
		logic init_last;
		logic ksa_last;
		logic prga_last;
		logic out_free;
	} status_t;

	// One byte of the widened nibble stream; odd positions are the zero bytes.
	function automatic logic [7:0] wide_byte(input logic [63:0] cand, input logic [4:0] m);
		logic [7:0] b;
		b = cand[{m[4:2], 3'b000} +: 8];
		if (m[0]) begin
			return 8'h00;
		end else if (m[1]) begin
			return {4'h0, b[3:0]} + LO_OFFSET;
		end else begin
			return {4'h0, b[7:4]} + HI_OFFSET;
		end
	endfunction

	// Standard base64 alphabet.
	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26) begin
			return w + 8'h41;
		end else if (v < 6'd52) begin
			return w + 8'h47;
		end else if (v < 6'd62) begin
			return w - 8'h04;
		end else if (v == 6'd62) begin
			return 8'h2b;
		end else begin
			return 8'h2f;
		end
	endfunction

	// Base64 character number c of the widened stream (c below 40).
	function automatic logic [7:0] key_char(input logic [63:0] cand, input logic [5:0] c);
		logic [4:0] g;
		logic [23:0] blk;
		logic [5:0] six;
		g = {c[5:2], 1'b0} + {1'b0, c[5:2]};
		blk = {wide_byte(cand, g), wide_byte(cand, g + 5'd1), wide_byte(cand, g + 5'd2)};
		case (c[1:0])
			2'd0: six = blk[23:18];
			2'd1: six = blk[17:12];
			2'd2: six = blk[11:6];
			default: six = blk[5:0];
		endcase
		return b64_char(six);
	endfunction

	function automatic logic [7:0] fold_case(input logic [7:0] v);
		if (v >= 8'h41 && v <= 8'h5a) begin
			return v + CASE_BIT;
		end
		return v;
	endfunction

endpackage

// ===== design/rc4cks_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rc4cks_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/rc4cks_ctrl.sv =====
// ----------------------------------------------------------------------------
// RC4 scorer controller
// Sequences table fill, key schedule, keystream steps and result handoff.
// ----------------------------------------------------------------------------
module rc4cks_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  rc4cks_pkg::status_t sts,
	output rc4cks_pkg::op_t     op
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_INIT, ST_K1, ST_K2, ST_K3, ST_K4,
		ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_DONE
	} state_t;

	state_t state_q;

	// Command decode from the current state.
	always_comb begin
		case (state_q)
			ST_IDLE: op = in_valid ? rc4cks_pkg::OP_LOAD : rc4cks_pkg::OP_NONE;
			ST_INIT: op = rc4cks_pkg::OP_INIT;
			ST_K1: op = rc4cks_pkg::OP_K1;
			ST_K2: op = rc4cks_pkg::OP_K2;
			ST_K3: op = rc4cks_pkg::OP_K3;
			ST_K4: op = rc4cks_pkg::OP_K4;
			ST_P1: op = rc4cks_pkg::OP_P1;
			ST_P2: op = rc4cks_pkg::OP_P2;
			ST_P3: op = rc4cks_pkg::OP_P3;
			ST_P4: op = rc4cks_pkg::OP_P4;
			ST_P5: op = rc4cks_pkg::OP_P5;
			ST_P6: op = rc4cks_pkg::OP_P6;
			ST_DONE: op = sts.out_free ? rc4cks_pkg::OP_PUB : rc4cks_pkg::OP_NONE;
			default: op = rc4cks_pkg::OP_NONE;
		endcase
	end

	// State register and registered input stall.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			in_stall <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_INIT;
						in_stall <= 1'b1;
					end
				end
				ST_INIT: if (sts.init_last) state_q <= ST_K1;
				ST_K1: state_q <= ST_K2;
				ST_K2: state_q <= ST_K3;
				ST_K3: state_q <= ST_K4;
				ST_K4: state_q <= sts.ksa_last ? ST_P1 : ST_K1;
				ST_P1: state_q <= ST_P2;
				ST_P2: state_q <= ST_P3;
				ST_P3: state_q <= ST_P4;
				ST_P4: state_q <= ST_P5;
				ST_P5: state_q <= ST_P6;
				ST_P6: state_q <= sts.prga_last ? ST_DONE : ST_P1;
				ST_DONE: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
						in_stall <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== design/rc4cks_dp.sv =====
// ----------------------------------------------------------------------------
// RC4 scorer datapath
// Key bytes, permutation table, indices, scoring and the output register.
// ----------------------------------------------------------------------------
module rc4cks_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  rc4cks_pkg::op_t     op,
	output rc4cks_pkg::status_t sts,
	input  logic [63:0]         candidate,
	input  logic                cfg_we,
	input  logic [3:0]          cfg_data,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [63:0]         plain_low,
	output logic [15:0]         plain_high,
	output logic [3:0]          exact_len,
	output logic [9:0]          dist_four,
	output logic [10:0]         dist_six,
	output logic [11:0]         dist_ten
);

	logic [3:0]  len_q;
	logic [63:0] cand_q;
	logic [6:0]  klen_q;
	logic [6:0]  kpos_q;
	logic [7:0]  k_q, i_q, j_q, t_q, sum_q;
	logic [3:0]  n_q;
	logic [7:0]  plain_q [rc4cks_pkg::PLAIN_BYTES];
	logic [3:0]  exact_q;
	logic        run_q;
	logic [9:0]  d4_q;
	logic [10:0] d6_q;
	logic [11:0] d10_q;

	logic        we;
	logic [7:0]  waddr, wdata, raddr, rdata;
	logic [7:0]  key_b, jn, pb, pf, gf, diff;

	rc4cks_ram #(
		.WIDTH (rc4cks_pkg::SBOX_WIDTH),
		.DEPTH (rc4cks_pkg::SBOX_DEPTH)
	) u_sbox (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Key byte at the current key position: base64 character or zero byte.
	assign key_b = kpos_q[0] ? 8'h00 : rc4cks_pkg::key_char(cand_q, kpos_q[6:1]);
	assign jn = j_q + rdata + key_b;

	// Plaintext byte and its distance to the target.
	assign pb = rdata ^ rc4cks_pkg::CIPHER[n_q];
	assign pf = rc4cks_pkg::fold_case(pb);
	assign gf = rc4cks_pkg::fold_case(rc4cks_pkg::GOAL[n_q]);
	assign diff = (pb > rc4cks_pkg::GOAL[n_q]) ? pb - rc4cks_pkg::GOAL[n_q]
		: rc4cks_pkg::GOAL[n_q] - pb;

	// Table port control.
	always_comb begin
		we = 1'b0;
		waddr = k_q;
		wdata = k_q;
		raddr = 8'h00;
		case (op)
			rc4cks_pkg::OP_INIT: we = 1'b1;
			rc4cks_pkg::OP_K1: raddr = k_q;
			rc4cks_pkg::OP_K2: raddr = jn;
			rc4cks_pkg::OP_K3: begin
				we = 1'b1;
				wdata = rdata;
			end
			rc4cks_pkg::OP_K4: begin
				we = 1'b1;
				waddr = j_q;
				wdata = t_q;
			end
			rc4cks_pkg::OP_P1: raddr = i_q + 8'd1;
			rc4cks_pkg::OP_P2: raddr = j_q + rdata;
			rc4cks_pkg::OP_P3: begin
				we = 1'b1;
				waddr = i_q;
				wdata = rdata;
			end
			rc4cks_pkg::OP_P4: begin
				we = 1'b1;
				waddr = j_q;
				wdata = t_q;
			end
			rc4cks_pkg::OP_P5: raddr = sum_q;
			default: ;
		endcase
	end

	assign sts.init_last = (k_q == 8'hff);
	assign sts.ksa_last = (k_q == 8'hff);
	assign sts.prga_last = (n_q == 4'(rc4cks_pkg::PLAIN_BYTES - 1));
	assign sts.out_free = !out_valid || !out_stall;

	// Length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= rc4cks_pkg::LEN_RESET;
		end else if (cfg_we) begin
			len_q <= cfg_data;
		end
	end

	// Output beat valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (op == rc4cks_pkg::OP_PUB) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// Working registers, one step per command.
	always_ff @(posedge clk) begin
		case (op)
			rc4cks_pkg::OP_LOAD: begin
				cand_q <= candidate;
				klen_q <= (len_q == rc4cks_pkg::LEN_LONG) ? rc4cks_pkg::KEY_LONG
					: rc4cks_pkg::KEY_SHORT;
				kpos_q <= 7'd0;
				k_q <= 8'd0;
				i_q <= 8'd0;
				j_q <= 8'd0;
				n_q <= 4'd0;
				exact_q <= 4'd0;
				run_q <= 1'b1;
				d4_q <= 10'd0;
				d6_q <= 11'd0;
				d10_q <= 12'd0;
			end
			rc4cks_pkg::OP_INIT: k_q <= k_q + 8'd1;
			rc4cks_pkg::OP_K2: begin
				t_q <= rdata;
				j_q <= jn;
			end
			rc4cks_pkg::OP_K4: begin
				k_q <= k_q + 8'd1;
				kpos_q <= (kpos_q == klen_q - 7'd1) ? 7'd0 : kpos_q + 7'd1;
				if (k_q == 8'hff) begin
					j_q <= 8'd0;
				end
			end
			rc4cks_pkg::OP_P1: i_q <= i_q + 8'd1;
			rc4cks_pkg::OP_P2: begin
				t_q <= rdata;
				j_q <= j_q + rdata;
			end
			rc4cks_pkg::OP_P3: sum_q <= t_q + rdata;
			rc4cks_pkg::OP_P6: begin
				plain_q[n_q] <= pb;
				n_q <= n_q + 4'd1;
				if (run_q && pf == gf) begin
					exact_q <= exact_q + 4'd1;
				end else begin
					run_q <= 1'b0;
				end
				if (n_q < 4'd4) begin
					d4_q <= d4_q + {2'b00, diff};
				end
				if (n_q < 4'd6) begin
					d6_q <= d6_q + {3'b000, diff};
				end
				d10_q <= d10_q + {4'h0, diff};
			end
			default: ;
		endcase
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (op == rc4cks_pkg::OP_PUB) begin
			plain_low <= {plain_q[7], plain_q[6], plain_q[5], plain_q[4],
				plain_q[3], plain_q[2], plain_q[1], plain_q[0]};
			plain_high <= {plain_q[9], plain_q[8]};
			exact_len <= exact_q;
			dist_four <= d4_q;
			dist_six <= d6_q;
			dist_ten <= d10_q;
		end
	end

endmodule

// ===== design/rc4_candidate_key_scorer_core.sv =====
// ----------------------------------------------------------------------------
// RC4 candidate key scorer
// Derives an RC4 key from an 8-byte candidate, decrypts ten bytes and scores.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_stall, candidate) takes one beat per
// candidate. in_stall is high from acceptance until the result has been moved
// into the output register, so one candidate is worked on at a time.
// Each candidate goes from acceptance to a valid output beat through the
// fill of the permutation table, the 256 key schedule steps (states K1 to
// K4 each), the ten keystream bytes (states P1 to P6 each) and the load of
// the output register. The single port pair of the permutation RAM splits
// each step into these states. A candidate beat is accepted in the idle
// state that follows the load of the previous result.
// The output channel (out_valid, out_stall, plain_low ... dist_ten) holds its
// beat while out_stall is high; the next candidate may be accepted while the
// previous result still waits there, and a finished result waits internally
// until the output register is free.
// cfg_we/cfg_data write the padded length (15 gives an 80-byte key, any
// other value a 76-byte key); write it only while the block is idle.
// Reset clears the controller, the output valid and sets the length to 14.
// ----------------------------------------------------------------------------
module rc4_candidate_key_scorer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] candidate,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] plain_low,
	output logic [15:0] plain_high,
	output logic [3:0]  exact_len,
	output logic [9:0]  dist_four,
	output logic [10:0] dist_six,
	output logic [11:0] dist_ten
);

	rc4cks_pkg::op_t     op;
	rc4cks_pkg::status_t sts;

	// Sequencer.
	rc4cks_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.op       (op)
	);

	// Datapath with permutation RAM.
	rc4cks_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.sts        (sts),
		.candidate  (candidate),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.plain_low  (plain_low),
		.plain_high (plain_high),
		.exact_len  (exact_len),
		.dist_four  (dist_four),
		.dist_six   (dist_six),
		.dist_ten   (dist_ten)
	);

endmodule

// ===== bench/rc4_candidate_key_scorer_core_tb.sv =====
// ----------------------------------------------------------------------------
// RC4 candidate key scorer testbench
// Drives candidates under several padded lengths and idling patterns, predicts
// each scored result with an independent key derivation and RC4 model, and
// compares every output beat field by field in order of acceptance.
// ----------------------------------------------------------------------------
module rc4_candidate_key_scorer_core_tb;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int DRAIN_CYCLES = 1500;
	localparam int RANDOM_PER_PHASE = 56;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct {
		logic [63:0] plain_low;
		logic [15:0] plain_high;
		logic [3:0]  exact_len;
		logic [9:0]  dist_four;
		logic [10:0] dist_six;
		logic [11:0] dist_ten;
	} score_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] candidate;
	logic        cfg_we;
	logic [3:0]  cfg_data;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] plain_low;
	logic [15:0] plain_high;
	logic [3:0]  exact_len;
	logic [9:0]  dist_four;
	logic [10:0] dist_six;
	logic [11:0] dist_ten;

	score_t     pending_scores[$];
	logic [3:0] pad_len;
	idle_mode_t idle_mode;
	int         fail_count;
	int         cycle_count;

	// Directed candidates: field extremes, pad-like bytes and bit patterns.
	logic [63:0] directed_rows [12] = '{
		64'h0000_0000_0000_0000, 64'hffff_ffff_ffff_ffff,
		64'h4141_4141_4141_4141, 64'h5555_5555_5555_5555,
		64'haaaa_aaaa_aaaa_aaaa, 64'h0123_4567_89ab_cdef,
		64'h8000_0000_0000_0001, 64'h0000_0000_0000_0001,
		64'h8000_0000_0000_0000, 64'h00ff_00ff_00ff_00ff,
		64'hff00_ff00_ff00_ff00, 64'h0f0f_f0f0_0f0f_f0f0
	};

	rc4_candidate_key_scorer_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .candidate(candidate),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.plain_low(plain_low), .plain_high(plain_high), .exact_len(exact_len),
		.dist_four(dist_four), .dist_six(dist_six), .dist_ten(dist_ten)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Scores one candidate: key derivation, RC4 schedule, ten keystream bytes.
	function automatic score_t score_candidate(input logic [63:0] cand, input logic [3:0] plen_reg);
		string      alphabet;
		int         plen, klen, g, sh;
		logic [7:0] padded [15];
		logic [7:0] wide [60];
		logic [7:0] key [80];
		logic [7:0] perm [256];
		logic [7:0] plain [10];
		logic [7:0] j, t, ii, jj, a, b;
		logic [23:0] blk;
		int         d, d10;
		bit         run;
		score_t     s;
		alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
		plen = (plen_reg == 4'd15) ? 15 : 14;
		klen = (plen == 15) ? 80 : 76;
		for (int k = 0; k < 15; k++) begin
			padded[k] = (k < 8) ? cand[8*k +: 8] : 8'h41;
		end
		for (int k = 0; k < 60; k++) begin
			wide[k] = 8'h00;
		end
		for (int k = 0; k < plen; k++) begin
			wide[4*k] = {4'h0, padded[k][7:4]} + 8'h78;
			wide[4*k+2] = {4'h0, padded[k][3:0]} + 8'h7a;
		end
		for (int k = 0; k < klen / 2; k++) begin
			g = (k / 4) * 3;
			blk = {wide[g], wide[g+1], wide[g+2]};
			sh = 18 - 6 * (k % 4);
			key[2*k] = alphabet[(blk >> sh) & 24'h3f];
			key[2*k+1] = 8'h00;
		end
		for (int k = 0; k < 256; k++) begin
			perm[k] = k[7:0];
		end
		j = 8'h00;
		for (int k = 0; k < 256; k++) begin
			t = perm[k];
			j = j + t + key[k % klen];
			perm[k] = perm[j];
			perm[j] = t;
		end
		ii = 8'h00;
		jj = 8'h00;
		for (int k = 0; k < 10; k++) begin
			ii = ii + 8'd1;
			jj = jj + perm[ii];
			t = perm[ii];
			perm[ii] = perm[jj];
			perm[jj] = t;
			plain[k] = rc4cks_pkg::CIPHER[k] ^ perm[8'(perm[ii] + perm[jj])];
		end
		// Scoring: case-folded prefix match and running L1 distances.
		run = 1'b1;
		d10 = 0;
		s.exact_len = 4'd0;
		s.dist_four = '0;
		s.dist_six = '0;
		for (int k = 0; k < 10; k++) begin
			a = (plain[k] >= 8'h41 && plain[k] <= 8'h5a) ? plain[k] + 8'h20 : plain[k];
			b = (rc4cks_pkg::GOAL[k] >= 8'h41 && rc4cks_pkg::GOAL[k] <= 8'h5a)
				? rc4cks_pkg::GOAL[k] + 8'h20 : rc4cks_pkg::GOAL[k];
			if (run && a == b) begin
				s.exact_len = s.exact_len + 4'd1;
			end else begin
				run = 1'b0;
			end
			d = (plain[k] > rc4cks_pkg::GOAL[k]) ? plain[k] - rc4cks_pkg::GOAL[k]
				: rc4cks_pkg::GOAL[k] - plain[k];
			d10 += d;
			if (k == 3) begin
				s.dist_four = d10[9:0];
			end
			if (k == 5) begin
				s.dist_six = d10[10:0];
			end
		end
		s.dist_ten = d10[11:0];
		for (int k = 0; k < 8; k++) begin
			s.plain_low[8*k +: 8] = plain[k];
		end
		s.plain_high = {plain[9], plain[8]};
		return s;
	endfunction

	// Receiver stall pattern, changed at the falling edge.
	always @(negedge clk) begin
		if (idle_mode == IDLE_RECEIVER) begin
			out_stall <= ($urandom_range(99) < 61);
		end else if (idle_mode == IDLE_BOTH) begin
			out_stall <= ($urandom_range(99) < 10);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Output beat checker against the oldest pending score.
	always @(posedge clk) begin
		score_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_scores.size() == 0) begin
				$error("output beat with no pending score");
				fail_count++;
			end else begin
				e = pending_scores.pop_front();
				if (plain_low !== e.plain_low) begin
					$error("plain_low expected %h actual %h", e.plain_low, plain_low);
					fail_count++;
				end
				if (plain_high !== e.plain_high) begin
					$error("plain_high expected %h actual %h", e.plain_high, plain_high);
					fail_count++;
				end
				if (exact_len !== e.exact_len) begin
					$error("exact_len expected %0d actual %0d", e.exact_len, exact_len);
					fail_count++;
				end
				if (dist_four !== e.dist_four) begin
					$error("dist_four expected %0d actual %0d", e.dist_four, dist_four);
					fail_count++;
				end
				if (dist_six !== e.dist_six) begin
					$error("dist_six expected %0d actual %0d", e.dist_six, dist_six);
					fail_count++;
				end
				if (dist_ten !== e.dist_ten) begin
					$error("dist_ten expected %0d actual %0d", e.dist_ten, dist_ten);
					fail_count++;
				end
			end
		end
	end

	// Run watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL rc4_candidate_key_scorer_core");
			$finish;
		end
	end

	// Sends one candidate beat, with sender gaps, and records its score.
	task automatic send_candidate(input logic [63:0] cand);
		int gap_pct;
		gap_pct = (idle_mode == IDLE_SENDER) ? 61 : (idle_mode == IDLE_BOTH) ? 10 : 0;
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		candidate <= cand;
		do begin
			@(posedge clk);
		end while (in_stall);
		pending_scores.push_back(score_candidate(cand, pad_len));
		@(negedge clk);
	endtask

	// Waits for the block to go idle, then writes the padded length.
	task automatic write_length(input logic [3:0] value);
		in_valid <= 1'b0;
		while (pending_scores.size() != 0 || out_valid || in_stall) begin
			@(negedge clk);
		end
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		pad_len = value;
	endtask

	function automatic logic [63:0] random_candidate();
		logic [63:0] c;
		c = {$urandom, $urandom};
		// Sometimes force bytes to their extremes or to the pad value.
		if ($urandom_range(3) == 0) begin
			for (int k = 0; k < 8; k++) begin
				case ($urandom_range(3))
					0: c[8*k +: 8] = 8'h00;
					1: c[8*k +: 8] = 8'hff;
					2: c[8*k +: 8] = 8'h41;
					default: ;
				endcase
			end
		end
		return c;
	endfunction

	initial begin
		logic [3:0]  phase_len [8] = '{4'd15, 4'd0, 4'd14, 4'd15, 4'd13, 4'd7, 4'd15, 4'd14};
		idle_mode_t  phase_idle [8] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
			IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
		fail_count = 0;
		cycle_count = 0;
		pad_len = 4'd14;
		idle_mode = IDLE_NONE;
		arst_n = 1'b0;
		in_valid = 1'b0;
		candidate = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		out_stall = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table under the reset length.
		foreach (directed_rows[r]) begin
			send_candidate(directed_rows[r]);
		end

		// Random phases across lengths and idling patterns.
		for (int p = 0; p < 8; p++) begin
			write_length(phase_len[p]);
			idle_mode = phase_idle[p];
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				send_candidate(random_candidate());
			end
			in_valid <= 1'b0;
		end

		while (pending_scores.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0) begin
			$display("PASS rc4_candidate_key_scorer_core");
		end else begin
			$display("FAIL rc4_candidate_key_scorer_core");
		end
		$finish;
	end

endmodule
